@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL, used by tfd_decide. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, off while rst is high.
`define TFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define TFD_ASSERT_IMPLY(label, ante, cons, msg) \
  `TFD_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ sv/tfd_pkg.sv @@
`default_nettype none

package tfd_pkg;

  localparam int ANGLE_W  = 16;
  localparam int LIMIT_W  = 15;
  localparam int RLIMIT_W = 22;
  localparam int TIME_W   = 32;
  localparam int SCALED_W = 26;
  localparam int BOUND_W  = RLIMIT_W + TIME_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0]   MIN_DT_MS  = TIME_W'(10);
  localparam logic [SCALED_W-1:0] RATE_SCALE = SCALED_W'(1000);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_ANGLE_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_RATE_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ANGLE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_INTERVAL_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_MS       = 3'd5;

  localparam logic [LIMIT_W-1:0]  RST_FALL_ANGLE  = LIMIT_W'(6000);
  localparam logic [RLIMIT_W-1:0] RST_FALL_RATE   = RLIMIT_W'(15000);
  localparam logic [LIMIT_W-1:0]  RST_LEVEL_ANGLE = LIMIT_W'(2000);
  localparam logic [TIME_W-1:0]   RST_ALERT_MS    = TIME_W'(30000);
  localparam logic [TIME_W-1:0]   RST_RECOVERY_MS = TIME_W'(5000);

  typedef struct packed {
    logic                monitor_enable;
    logic [LIMIT_W-1:0]  fall_angle_limit;
    logic [RLIMIT_W-1:0] fall_rate_limit;
    logic [LIMIT_W-1:0]  level_angle_limit;
    logic [TIME_W-1:0]   alert_interval_ms;
    logic [TIME_W-1:0]   recovery_ms;
  } tfd_cfg_t;

  // front stage -> rate stage
  typedef struct packed {
    logic               valid;
    logic               en;
    logic               have_prev;
    logic [TIME_W-1:0]  t;
    logic [TIME_W-1:0]  dt;
    logic [ANGLE_W-1:0] ap;
    logic [ANGLE_W-1:0] ar;
    logic [ANGLE_W-1:0] dp;
    logic [ANGLE_W-1:0] dr;
  } tfd_delta_t;

  // rate stage -> decision stage
  typedef struct packed {
    logic                valid;
    logic                en;
    logic                have_prev;
    logic [TIME_W-1:0]   t;
    logic                abnormal;
    logic                level;
    logic [BOUND_W-1:0]  bound;
    logic [SCALED_W-1:0] dp_scaled;
    logic [SCALED_W-1:0] dr_scaled;
  } tfd_check_t;

  typedef enum logic [1:0] {
    ST_UPRIGHT,
    ST_FALLEN_TILTED,
    ST_FALLEN_LEVEL
  } tfd_state_t;

  function automatic logic [ANGLE_W-1:0] tfd_mag(input logic signed [ANGLE_W:0] v);
    return v[ANGLE_W] ? ANGLE_W'(-v) : ANGLE_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ sv/tfd_channels.sv @@
`default_nettype none

interface tfd_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] pitch_angle;
  logic [15:0] roll_angle;
  logic [31:0] sample_time_ms;

  modport source (output valid, pitch_angle, roll_angle, sample_time_ms, input ready);
  modport sink   (input valid, pitch_angle, roll_angle, sample_time_ms, output ready);
endinterface

interface tfd_result_if;
  logic valid;
  logic ready;
  logic fall_detected;
  logic still_fallen_alert;
  logic stable_started;
  logic recovered;
  logic fallen_now;

  modport source (output valid, fall_detected, still_fallen_alert, stable_started,
                  recovered, fallen_now, input ready);
  modport sink   (input valid, fall_detected, still_fallen_alert, stable_started,
                  recovered, fallen_now, output ready);
endinterface

`default_nettype wire

@@ sv/tfd_front.sv @@
`default_nettype none

module tfd_front
  import tfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tfd_cfg_t           cfg,
  input  wire logic               advance,
  input  wire logic               in_valid,
  input  wire logic [ANGLE_W-1:0] pitch_angle,
  input  wire logic [ANGLE_W-1:0] roll_angle,
  input  wire logic [TIME_W-1:0]  sample_time_ms,
  output tfd_delta_t              delta
);

  logic               have_previous;
  logic [ANGLE_W-1:0] prev_pitch;
  logic [ANGLE_W-1:0] prev_roll;
  logic [TIME_W-1:0]  prev_time;

  logic               accept;
  logic [TIME_W-1:0]  dt_raw;
  tfd_delta_t         delta_next;

  assign accept = in_valid && advance;
  assign dt_raw = sample_time_ms - prev_time;

  always_comb begin
    delta_next.valid     = accept;
    delta_next.en        = cfg.monitor_enable;
    delta_next.have_prev = have_previous;
    delta_next.t         = sample_time_ms;
    delta_next.dt        = (dt_raw < MIN_DT_MS) ? MIN_DT_MS : dt_raw;
    delta_next.ap        = tfd_mag({pitch_angle[ANGLE_W-1], pitch_angle});
    delta_next.ar        = tfd_mag({roll_angle[ANGLE_W-1], roll_angle});
    delta_next.dp        = tfd_mag({pitch_angle[ANGLE_W-1], pitch_angle}
                                   - {prev_pitch[ANGLE_W-1], prev_pitch});
    delta_next.dr        = tfd_mag({roll_angle[ANGLE_W-1], roll_angle}
                                   - {prev_roll[ANGLE_W-1], prev_roll});
  end

  // previous sample: record every accepted beat while monitoring
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      prev_pitch    <= '0;
      prev_roll     <= '0;
      prev_time     <= '0;
    end else if (accept && cfg.monitor_enable) begin
      have_previous <= 1'b1;
      prev_pitch    <= pitch_angle;
      prev_roll     <= roll_angle;
      prev_time     <= sample_time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta.valid <= 1'b0;
    end else if (advance) begin
      delta <= delta_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/tfd_rate.sv @@
`default_nettype none

module tfd_rate
  import tfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire tfd_cfg_t   cfg,
  input  wire logic       advance,
  input  wire tfd_delta_t delta,
  output tfd_check_t      check
);

  tfd_check_t check_next;

  always_comb begin
    check_next.valid     = delta.valid;
    check_next.en        = delta.en;
    check_next.have_prev = delta.have_prev;
    check_next.t         = delta.t;
    check_next.abnormal  = (delta.ap > ANGLE_W'(cfg.fall_angle_limit))
                        || (delta.ar > ANGLE_W'(cfg.fall_angle_limit));
    check_next.level     = (delta.ap <= ANGLE_W'(cfg.level_angle_limit))
                        && (delta.ar <= ANGLE_W'(cfg.level_angle_limit));
    // rate limit scaled by elapsed ms, against the angle step scaled to seconds
    check_next.bound     = BOUND_W'(cfg.fall_rate_limit) * BOUND_W'(delta.dt);
    check_next.dp_scaled = SCALED_W'(delta.dp) * RATE_SCALE;
    check_next.dr_scaled = SCALED_W'(delta.dr) * RATE_SCALE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check.valid <= 1'b0;
    end else if (advance) begin
      check <= check_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/tfd_decide.sv @@
`default_nettype none

`include "assert_macros.svh"

module tfd_decide
  import tfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire tfd_cfg_t   cfg,
  input  wire logic       advance,
  input  wire tfd_check_t check,
  tfd_result_if.source    result
);

  tfd_state_t        state;
  tfd_state_t        state_next;
  logic [TIME_W-1:0] stable_since;
  logic [TIME_W-1:0] stable_since_next;
  logic [TIME_W-1:0] last_alert_time;
  logic [TIME_W-1:0] last_alert_time_next;

  logic              high_rate;
  logic              alert_due;
  logic              recovery_due;
  logic              active;
  logic              ev_fall;
  logic              ev_alert;
  logic              ev_stable;
  logic              ev_rec;

  assign high_rate    = (BOUND_W'(check.dp_scaled) > check.bound)
                     || (BOUND_W'(check.dr_scaled) > check.bound);
  assign alert_due    = (check.t - last_alert_time) > cfg.alert_interval_ms;
  assign recovery_due = (check.t - stable_since) > cfg.recovery_ms;
  assign active       = check.valid && check.en && check.have_prev;

  always_comb begin
    state_next           = state;
    stable_since_next    = stable_since;
    last_alert_time_next = last_alert_time;
    ev_fall              = 1'b0;
    ev_alert             = 1'b0;
    ev_stable            = 1'b0;
    ev_rec               = 1'b0;
    if (active) begin
      unique case (state)
        ST_UPRIGHT: begin
          if (check.abnormal && high_rate) begin
            state_next = ST_FALLEN_TILTED;
            ev_fall    = 1'b1;
          end
        end
        ST_FALLEN_TILTED: begin
          if (!check.level) begin
            if (alert_due) begin
              ev_alert             = 1'b1;
              last_alert_time_next = check.t;
            end
          end else begin
            state_next        = ST_FALLEN_LEVEL;
            stable_since_next = check.t;
            ev_stable         = 1'b1;
          end
        end
        ST_FALLEN_LEVEL: begin
          if (!check.level) begin
            state_next = ST_FALLEN_TILTED;
            if (alert_due) begin
              ev_alert             = 1'b1;
              last_alert_time_next = check.t;
            end
          end else if (recovery_due) begin
            state_next = ST_UPRIGHT;
            ev_rec     = 1'b1;
          end
        end
        default: state_next = ST_UPRIGHT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_UPRIGHT;
      stable_since    <= '0;
      last_alert_time <= '0;
    end else if (advance) begin
      state           <= state_next;
      stable_since    <= stable_since_next;
      last_alert_time <= last_alert_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= check.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.fall_detected      <= ev_fall;
      result.still_fallen_alert <= ev_alert;
      result.stable_started     <= ev_stable;
      result.recovered          <= ev_rec;
      result.fallen_now         <= (state_next != ST_UPRIGHT);
    end
  end

  `TFD_ASSERT(a_one_event, result.valid |-> $onehot0({result.fall_detected, result.still_fallen_alert, result.stable_started, result.recovered}), "more than one event in a result")
  `TFD_ASSERT_IMPLY(a_fall_sets_flag, result.valid && result.fall_detected, result.fallen_now, "fall reported without fallen flag")
  `TFD_ASSERT_IMPLY(a_rec_clears_flag, result.valid && result.recovered, !result.fallen_now, "recovery reported with fallen flag set")
  `TFD_ASSERT(a_state_holds_in_stall, !advance |=> $stable(state) && $stable(last_alert_time), "state moved while the pipeline was stalled")

endmodule

`default_nettype wire

@@ sv/tilt_fall_detector.sv @@
// Tilt fall detector.
// sample (sink): one orientation beat per handshake - pitch and roll in
//   centidegrees (signed) and a millisecond timestamp that wraps at 2^32.
// result (source): one beat per sample with the four event flags and the
//   fallen flag after that sample.
// cfg_we/cfg_index/cfg_data: register writes, taken at any edge with cfg_we
//   high; write only while no sample is in flight.
// Path: an accepted sample is loaded into the front register, then the rate
//   multiply register, then the decision/result register, and leaves from
//   the result register on the result handshake.
// Throughput: one sample per cycle; the fall/recovery state is updated in
//   the last stage only, so a new beat can enter every cycle unless stalled.
// Stall: when the result is held (valid without ready) the whole pipeline
//   holds, and sample.ready drops in the same cycle.
// Reset: clears all valid bits, the fallen state and the previous-sample
//   memory; registers return to their documented defaults, monitoring off.
`default_nettype none

module tilt_fall_detector
  import tfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  tfd_sample_if.sink                 sample,
  tfd_result_if.source               result
);

  tfd_cfg_t   cfg;
  tfd_delta_t delta;
  tfd_check_t check;
  logic       advance;

  // Advance every stage together unless the result register is blocked.
  assign advance      = !result.valid || result.ready;
  assign sample.ready = advance;

  // Configuration registers; unused indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.monitor_enable    <= 1'b0;
      cfg.fall_angle_limit  <= RST_FALL_ANGLE;
      cfg.fall_rate_limit   <= RST_FALL_RATE;
      cfg.level_angle_limit <= RST_LEVEL_ANGLE;
      cfg.alert_interval_ms <= RST_ALERT_MS;
      cfg.recovery_ms       <= RST_RECOVERY_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MONITOR_ENABLE:    cfg.monitor_enable    <= cfg_data[0];
        CFG_FALL_ANGLE_LIMIT:  cfg.fall_angle_limit  <= cfg_data[LIMIT_W-1:0];
        CFG_FALL_RATE_LIMIT:   cfg.fall_rate_limit   <= cfg_data[RLIMIT_W-1:0];
        CFG_LEVEL_ANGLE_LIMIT: cfg.level_angle_limit <= cfg_data[LIMIT_W-1:0];
        CFG_ALERT_INTERVAL_MS: cfg.alert_interval_ms <= cfg_data[TIME_W-1:0];
        CFG_RECOVERY_MS:       cfg.recovery_ms       <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: magnitudes, angle steps and clamped elapsed time.
  tfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .advance        (advance),
    .in_valid       (sample.valid),
    .pitch_angle    (sample.pitch_angle),
    .roll_angle     (sample.roll_angle),
    .sample_time_ms (sample.sample_time_ms),
    .delta          (delta)
  );

  // Stage 2: threshold compares, scaled steps, rate-times-elapsed product.
  tfd_rate u_rate (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .delta   (delta),
    .check   (check)
  );

  // Stage 3: fall/alert/recovery state and the result register.
  tfd_decide u_decide (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .check   (check),
    .result  (result)
  );

endmodule

`default_nettype wire
